// ----- hdl/assert_macros.svh -----
// Assertion macros of the strip block, included by its top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define LSDP_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);
`define LSDP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define LSDP_ASSERT(lbl, clk, rst_n, prop, msg)
`define LSDP_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

// ----- hdl/lsdp_pkg.sv -----
// Package with types, constants, scaling and maximum functions of the strip block.
package lsdp_pkg;

    localparam int IDX_W              = 6;
    localparam int CH_W               = 8;
    localparam int KEEP_W             = 9;
    localparam int OP_W               = 2;
    localparam int CFG_IDX_W          = 1;
    localparam int NUM_PIXELS_DEFAULT = 64;

    localparam logic [KEEP_W-1:0] KEEP_FULL = 9'd256;

    localparam logic [OP_W-1:0] OP_WRITE      = 2'd0;
    localparam logic [OP_W-1:0] OP_SHIFT_LOW  = 2'd1;
    localparam logic [OP_W-1:0] OP_SHIFT_HIGH = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_PIXEL_KEEP  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_TRAVEL_KEEP = 1'b1;

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
    } t_rgb;

    typedef struct packed {
        logic [OP_W-1:0]  operation;
        logic [IDX_W-1:0] first_index;
        logic [IDX_W-1:0] last_index;
        logic [CH_W-1:0]  red_in;
        logic [CH_W-1:0]  green_in;
        logic [CH_W-1:0]  blue_in;
    } t_in_req;

    typedef struct packed {
        logic [IDX_W-1:0] pixel_out;
        logic [CH_W-1:0]  red_out;
        logic [CH_W-1:0]  green_out;
        logic [CH_W-1:0]  blue_out;
        logic             last_of_run;
    } t_out_res;

    typedef struct packed {
        logic             wr_en;
        logic [IDX_W-1:0] wr_addr;
        t_rgb             wr_data;
        logic             rd_en;
        logic [IDX_W-1:0] rd_addr;
    } t_mem_req;

    function automatic logic [CH_W-1:0] scale_channel(input logic [CH_W-1:0]   ch,
                                                      input logic [KEEP_W-1:0] keep);
        logic [KEEP_W-1:0]      k;
        logic [CH_W+KEEP_W-1:0] prod;
        k    = (keep > KEEP_FULL) ? KEEP_FULL : keep;
        prod = {{KEEP_W{1'b0}}, ch} * {{CH_W{1'b0}}, k};
        return prod[2*CH_W-1:CH_W];
    endfunction

    function automatic logic [CH_W-1:0] max_channel(input logic [CH_W-1:0] a,
                                                    input logic [CH_W-1:0] b);
        return (a > b) ? a : b;
    endfunction

endpackage

// ----- hdl/lsdp_mix.sv -----
// Per-channel blend of a pixel with its neighbor: scale both, keep the larger.
module lsdp_mix (
    input  lsdp_pkg::t_rgb                 i_own,
    input  lsdp_pkg::t_rgb                 i_nb,
    input  logic [lsdp_pkg::KEEP_W-1:0]    i_pixel_keep,
    input  logic [lsdp_pkg::KEEP_W-1:0]    i_travel_keep,
    output lsdp_pkg::t_rgb                 o_mix
);

    lsdp_pkg::t_rgb own_s;
    lsdp_pkg::t_rgb nb_s;

    always_comb begin
        own_s.red   = lsdp_pkg::scale_channel(i_own.red,   i_pixel_keep);
        own_s.green = lsdp_pkg::scale_channel(i_own.green, i_pixel_keep);
        own_s.blue  = lsdp_pkg::scale_channel(i_own.blue,  i_pixel_keep);
        nb_s.red    = lsdp_pkg::scale_channel(i_nb.red,    i_travel_keep);
        nb_s.green  = lsdp_pkg::scale_channel(i_nb.green,  i_travel_keep);
        nb_s.blue   = lsdp_pkg::scale_channel(i_nb.blue,   i_travel_keep);
        o_mix.red   = lsdp_pkg::max_channel(own_s.red,   nb_s.red);
        o_mix.green = lsdp_pkg::max_channel(own_s.green, nb_s.green);
        o_mix.blue  = lsdp_pkg::max_channel(own_s.blue,  nb_s.blue);
    end

endmodule

// ----- hdl/lsdp_pixel_mem.sv -----
// Pixel color memory: one write and one registered read port, per-entry valid bits.
module lsdp_pixel_mem #(
    parameter int NUM_PIXELS = lsdp_pkg::NUM_PIXELS_DEFAULT
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  lsdp_pkg::t_mem_req i_req,
    output lsdp_pkg::t_rgb     o_rd_data
);

    localparam int AW = (NUM_PIXELS > 1) ? $clog2(NUM_PIXELS) : 1;

    lsdp_pkg::t_rgb r_mem [NUM_PIXELS];
    logic           r_valid [NUM_PIXELS];
    lsdp_pkg::t_rgb r_rd_data;

    logic [AW-1:0] wr_a;
    logic [AW-1:0] rd_a;

    assign wr_a = i_req.wr_addr[AW-1:0];
    assign rd_a = i_req.rd_addr[AW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_PIXELS; i++) begin
                r_valid[i] <= 1'b0;
            end
        end else if (i_req.wr_en) begin
            r_valid[wr_a] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[wr_a] <= i_req.wr_data;
        end
        if (i_req.rd_en) begin
            r_rd_data <= r_valid[rd_a] ? r_mem[rd_a] : '0;
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- hdl/led_strip_decay_propagate_core.sv -----
// Top level of the LED strip decay and propagate block.
//
//  channel  direction  handshake                  payload
//  in       request    i_in_valid / o_in_stall    i_in_data  (lsdp_pkg::t_in_req)
//  out      result     o_out_valid / i_out_stall  o_out_data (lsdp_pkg::t_out_res)
//  cfg      write      i_cfg_wr_en                i_cfg_index, i_cfg_data
//
// A write request passes through the write state; a shift primes a read, then steps
// one pixel per cycle unless the result stalls, through the read-modify-write of the
// pixel memory. An empty shift or an unused operation returns nothing.
// Reset clears the control state and the memory valid bits; the strip reads black.
// A stalled result holds the walk; the next request waits until the walk ends.
`include "assert_macros.svh"

module led_strip_decay_propagate_core #(
    parameter int NUM_PIXELS = lsdp_pkg::NUM_PIXELS_DEFAULT
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  lsdp_pkg::t_in_req              i_in_data,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output lsdp_pkg::t_out_res             o_out_data,
    input  logic                           i_cfg_wr_en,
    input  logic [lsdp_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [lsdp_pkg::KEEP_W-1:0]    i_cfg_data
);

    localparam logic [lsdp_pkg::IDX_W-1:0] MAX_IDX = lsdp_pkg::IDX_W'(NUM_PIXELS - 1);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_WRITE = 4'b0010,
        S_PRIME = 4'b0100,
        S_STEP  = 4'b1000
    } t_state;

    t_state                          r_state, n_state;
    logic                            r_dir, n_dir;
    logic [lsdp_pkg::IDX_W-1:0]      r_cur, n_cur;
    logic [lsdp_pkg::IDX_W-1:0]      r_end, n_end;
    lsdp_pkg::t_rgb                  r_wcolor, n_wcolor;
    lsdp_pkg::t_rgb                  r_own, n_own;
    logic                            r_out_valid, n_out_valid;
    lsdp_pkg::t_out_res              r_out, n_out;
    logic [lsdp_pkg::KEEP_W-1:0]     r_pixel_keep;
    logic [lsdp_pkg::KEEP_W-1:0]     r_travel_keep;

    lsdp_pkg::t_mem_req              mem_req;
    lsdp_pkg::t_rgb                  rd_data;
    lsdp_pkg::t_rgb                  mix;
    logic                            out_free;
    logic                            in_accept;
    logic [lsdp_pkg::IDX_W-1:0]      first_c;
    logic [lsdp_pkg::IDX_W-1:0]      last_c;
    logic [lsdp_pkg::IDX_W-1:0]      next_idx;
    logic [lsdp_pkg::IDX_W-1:0]      next2_idx;

    lsdp_pixel_mem #(
        .NUM_PIXELS(NUM_PIXELS)
    ) u_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (mem_req),
        .o_rd_data (rd_data)
    );

    lsdp_mix u_mix (
        .i_own         (r_own),
        .i_nb          (rd_data),
        .i_pixel_keep  (r_pixel_keep),
        .i_travel_keep (r_travel_keep),
        .o_mix         (mix)
    );

    assign out_free   = !r_out_valid || !i_out_stall;
    assign o_in_stall = (r_state != S_IDLE);
    assign in_accept  = i_in_valid && (r_state == S_IDLE);
    assign first_c    = (i_in_data.first_index > MAX_IDX) ? MAX_IDX : i_in_data.first_index;
    assign last_c     = (i_in_data.last_index > MAX_IDX) ? MAX_IDX : i_in_data.last_index;
    assign next_idx   = r_dir ? (r_cur - lsdp_pkg::IDX_W'(1)) : (r_cur + lsdp_pkg::IDX_W'(1));
    assign next2_idx  = r_dir ? (r_cur - lsdp_pkg::IDX_W'(2)) : (r_cur + lsdp_pkg::IDX_W'(2));

    always_comb begin
        n_state     = r_state;
        n_dir       = r_dir;
        n_cur       = r_cur;
        n_end       = r_end;
        n_wcolor    = r_wcolor;
        n_own       = r_own;
        n_out_valid = r_out_valid && i_out_stall;
        n_out       = r_out;
        mem_req     = '0;
        case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    case (i_in_data.operation)
                        lsdp_pkg::OP_WRITE: begin
                            n_cur          = first_c;
                            n_wcolor.red   = i_in_data.red_in;
                            n_wcolor.green = i_in_data.green_in;
                            n_wcolor.blue  = i_in_data.blue_in;
                            n_state        = S_WRITE;
                        end
                        lsdp_pkg::OP_SHIFT_LOW: begin
                            if (first_c < last_c) begin
                                n_dir           = 1'b0;
                                n_cur           = first_c;
                                n_end           = last_c;
                                mem_req.rd_en   = 1'b1;
                                mem_req.rd_addr = first_c;
                                n_state         = S_PRIME;
                            end
                        end
                        lsdp_pkg::OP_SHIFT_HIGH: begin
                            if (first_c < last_c) begin
                                n_dir           = 1'b1;
                                n_cur           = last_c;
                                n_end           = first_c;
                                mem_req.rd_en   = 1'b1;
                                mem_req.rd_addr = last_c;
                                n_state         = S_PRIME;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_WRITE: begin
                if (out_free) begin
                    mem_req.wr_en     = 1'b1;
                    mem_req.wr_addr   = r_cur;
                    mem_req.wr_data   = r_wcolor;
                    n_out_valid       = 1'b1;
                    n_out.pixel_out   = r_cur;
                    n_out.red_out     = r_wcolor.red;
                    n_out.green_out   = r_wcolor.green;
                    n_out.blue_out    = r_wcolor.blue;
                    n_out.last_of_run = 1'b1;
                    n_state           = S_IDLE;
                end
            end
            S_PRIME: begin
                n_own           = rd_data;
                mem_req.rd_en   = 1'b1;
                mem_req.rd_addr = next_idx;
                n_state         = S_STEP;
            end
            S_STEP: begin
                if (out_free) begin
                    mem_req.wr_en     = 1'b1;
                    mem_req.wr_addr   = r_cur;
                    mem_req.wr_data   = mix;
                    n_out_valid       = 1'b1;
                    n_out.pixel_out   = r_cur;
                    n_out.red_out     = mix.red;
                    n_out.green_out   = mix.green;
                    n_out.blue_out    = mix.blue;
                    n_out.last_of_run = (next_idx == r_end);
                    n_own             = rd_data;
                    n_cur             = next_idx;
                    if (next_idx == r_end) begin
                        n_state = S_IDLE;
                    end else begin
                        mem_req.rd_en   = 1'b1;
                        mem_req.rd_addr = next2_idx;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_out_valid   <= 1'b0;
            r_pixel_keep  <= lsdp_pkg::KEEP_FULL;
            r_travel_keep <= lsdp_pkg::KEEP_FULL;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    lsdp_pkg::CFG_PIXEL_KEEP:  r_pixel_keep  <= i_cfg_data;
                    lsdp_pkg::CFG_TRAVEL_KEEP: r_travel_keep <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_dir    <= n_dir;
        r_cur    <= n_cur;
        r_end    <= n_end;
        r_wcolor <= n_wcolor;
        r_own    <= n_own;
        r_out    <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    `LSDP_ASSERT(a_state_onehot, i_clk, i_rst_n, $onehot(r_state), "state not one-hot")
    `LSDP_ASSERT(a_step_before_end, i_clk, i_rst_n, (r_state == S_STEP) |-> (r_cur != r_end), "walk reached its end pixel")
    `LSDP_ASSERT(a_write_has_slot, i_clk, i_rst_n, mem_req.wr_en |-> out_free, "pixel written without a free result slot")
    `LSDP_ASSERT(a_idle_no_write, i_clk, i_rst_n, (r_state == S_IDLE) |-> !mem_req.wr_en, "memory written while idle")

endmodule

// ----- tb/tb_led_strip_decay_propagate_core.sv -----
// Testbench for the LED strip decay and propagate core: directed and random requests, scoreboard check.

class pixel_walk_scoreboard;
    localparam int STRIP_LEN = lsdp_pkg::NUM_PIXELS_DEFAULT;

    lsdp_pkg::t_rgb                      strip[STRIP_LEN];
    logic [lsdp_pkg::KEEP_W-1:0]         own_keep;
    logic [lsdp_pkg::KEEP_W-1:0]         carry_keep;
    lsdp_pkg::t_out_res                  expected_pixels[$];
    int                                  errors;

    function new();
        foreach (strip[i]) strip[i] = '0;
        own_keep   = lsdp_pkg::KEEP_FULL;
        carry_keep = lsdp_pkg::KEEP_FULL;
        errors     = 0;
    endfunction

    function void set_keep(input logic [lsdp_pkg::CFG_IDX_W-1:0] index,
                           input logic [lsdp_pkg::KEEP_W-1:0]    value);
        if (index == lsdp_pkg::CFG_PIXEL_KEEP) begin
            own_keep = value;
        end else begin
            carry_keep = value;
        end
    endfunction

    function logic [7:0] attenuate(input logic [7:0] ch, input logic [8:0] keep);
        logic [16:0] product;
        product = ch * ((keep > 9'd256) ? 9'd256 : keep);
        return product[15:8];
    endfunction

    function lsdp_pkg::t_rgb blend(input lsdp_pkg::t_rgb own_c, input lsdp_pkg::t_rgb nb);
        lsdp_pkg::t_rgb mixed;
        logic [7:0]     a;
        logic [7:0]     b;
        a = attenuate(own_c.red, own_keep);
        b = attenuate(nb.red, carry_keep);
        mixed.red = (a > b) ? a : b;
        a = attenuate(own_c.green, own_keep);
        b = attenuate(nb.green, carry_keep);
        mixed.green = (a > b) ? a : b;
        a = attenuate(own_c.blue, own_keep);
        b = attenuate(nb.blue, carry_keep);
        mixed.blue = (a > b) ? a : b;
        return mixed;
    endfunction

    function void push_pixel(input int idx, input bit closing);
        lsdp_pkg::t_out_res item;
        item.pixel_out   = idx[lsdp_pkg::IDX_W-1:0];
        item.red_out     = strip[idx].red;
        item.green_out   = strip[idx].green;
        item.blue_out    = strip[idx].blue;
        item.last_of_run = closing;
        expected_pixels.push_back(item);
    endfunction

    function void note_request(input lsdp_pkg::t_in_req r);
        int lo;
        int hi;
        lo = (r.first_index > STRIP_LEN - 1) ? STRIP_LEN - 1 : r.first_index;
        hi = (r.last_index > STRIP_LEN - 1) ? STRIP_LEN - 1 : r.last_index;
        case (r.operation)
            lsdp_pkg::OP_WRITE: begin
                strip[lo] = {r.red_in, r.green_in, r.blue_in};
                push_pixel(lo, 1'b1);
            end
            lsdp_pkg::OP_SHIFT_LOW: begin
                for (int i = lo; i < hi; i++) begin
                    strip[i] = blend(strip[i], strip[i + 1]);
                    push_pixel(i, i + 1 == hi);
                end
            end
            lsdp_pkg::OP_SHIFT_HIGH: begin
                for (int i = hi; i > lo; i--) begin
                    strip[i] = blend(strip[i], strip[i - 1]);
                    push_pixel(i, i - 1 == lo);
                end
            end
            default: begin
            end
        endcase
    endfunction

    function int pending();
        return expected_pixels.size();
    endfunction

    function void compare_field(input string name, input int unsigned want,
                                input int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            errors++;
        end
    endfunction

    function void check_pixel(input lsdp_pkg::t_out_res got);
        lsdp_pkg::t_out_res want;
        if (expected_pixels.size() == 0) begin
            $display("%0t: unexpected pixel, expected none, actual %0d rgb %0d %0d %0d",
                     $time, got.pixel_out, got.red_out, got.green_out, got.blue_out);
            errors++;
            return;
        end
        want = expected_pixels.pop_front();
        compare_field("pixel_out", want.pixel_out, got.pixel_out);
        compare_field("red_out", want.red_out, got.red_out);
        compare_field("green_out", want.green_out, got.green_out);
        compare_field("blue_out", want.blue_out, got.blue_out);
        compare_field("last_of_run", want.last_of_run, got.last_of_run);
    endfunction
endclass

module tb_led_strip_decay_propagate_core;
    import lsdp_pkg::*;

    localparam int              STRIP_LEN       = NUM_PIXELS_DEFAULT;
    localparam int              IN_REQ_W        = $bits(t_in_req);
    localparam logic [OP_W-1:0] OP_UNUSED       = 2'd3;
    localparam int              PHASES          = 8;
    localparam int              ITEMS_PER_PHASE = 22;
    localparam int              SETTLE_CYCLES   = 8;
    localparam int              DRAIN_CYCLES    = STRIP_LEN + 16;
    localparam int              HOLD_OFF_CYCLES = 400;
    localparam int              WATCHDOG_LIMIT  = 3000;

    logic                 clk;
    logic                 rst_n;
    logic                 req_valid;
    logic                 req_stall;
    t_in_req              req_data;
    logic                 res_valid;
    logic                 res_stall;
    t_out_res             res_data;
    logic                 cfg_wr_en;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [KEEP_W-1:0]    cfg_data;

    pixel_walk_scoreboard sb;
    bit                   hold_off_due;
    int                   burst_left;
    int                   quiet_cycles;
    logic [KEEP_W-1:0]    own_settings[PHASES];
    logic [KEEP_W-1:0]    carry_settings[PHASES];

    led_strip_decay_propagate_core #(
        .NUM_PIXELS(STRIP_LEN)
    ) dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (req_valid),
        .o_in_stall (req_stall),
        .i_in_data  (req_data),
        .o_out_valid(res_valid),
        .i_out_stall(res_stall),
        .o_out_data (res_data),
        .i_cfg_wr_en(cfg_wr_en),
        .i_cfg_index(cfg_index),
        .i_cfg_data (cfg_data)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial begin
        int mode;
        int span;
        res_stall = 1'b0;
        forever begin
            if (hold_off_due) begin
                hold_off_due = 1'b0;
                @(negedge clk);
                res_stall = 1'b1;
                repeat (HOLD_OFF_CYCLES - 1) @(negedge clk);
            end else begin
                mode = $urandom_range(0, 3);
                span = $urandom_range(4, 40);
                repeat (span) begin
                    @(negedge clk);
                    case (mode)
                        0: res_stall = 1'b0;
                        1: res_stall = 1'($urandom_range(0, 1));
                        2: res_stall = ($urandom_range(0, 4) == 0);
                        default: res_stall = 1'b1;
                    endcase
                end
            end
        end
    end

    always @(posedge clk) begin
        if (rst_n && res_valid && !res_stall) begin
            sb.check_pixel(res_data);
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (req_valid && !req_stall) || (res_valid && !res_stall)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no progress for %0d cycles", $time, quiet_cycles);
            $display("FAIL led_strip_decay_propagate_core");
            $finish;
        end
    end

    function automatic t_in_req make_req(input logic [OP_W-1:0] op, input int lo, input int hi,
                                         input logic [7:0] r, input logic [7:0] g,
                                         input logic [7:0] b);
        t_in_req req;
        req.operation   = op;
        req.first_index = lo[IDX_W-1:0];
        req.last_index  = hi[IDX_W-1:0];
        req.red_in      = r;
        req.green_in    = g;
        req.blue_in     = b;
        return req;
    endfunction

    function automatic logic [7:0] random_channel();
        int pick;
        pick = $urandom_range(0, 7);
        if (pick == 0) return 8'd0;
        if (pick == 1) return 8'd255;
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic t_in_req random_request(output bit counted);
        t_in_req req;
        int      pick;
        int      lo;
        int      hi;
        pick    = $urandom_range(0, 99);
        counted = 1'b1;
        req     = make_req(OP_WRITE, $urandom_range(0, STRIP_LEN - 1),
                           $urandom_range(0, STRIP_LEN - 1),
                           random_channel(), random_channel(), random_channel());
        if (pick < 40) begin
            return req;
        end
        if (pick < 85) begin
            lo = $urandom_range(0, STRIP_LEN - 2);
            hi = lo + $urandom_range(1, 8);
            if (hi > STRIP_LEN - 1) hi = STRIP_LEN - 1;
        end else if (pick < 92) begin
            lo = $urandom_range(0, 8);
            hi = $urandom_range(STRIP_LEN - 9, STRIP_LEN - 1);
        end else begin
            // drop into an empty range or the unused code
            counted = 1'b0;
            lo = $urandom_range(0, STRIP_LEN - 1);
            hi = $urandom_range(0, lo);
            if ($urandom_range(0, 1) == 1) begin
                req.operation = OP_UNUSED;
                hi = $urandom_range(0, STRIP_LEN - 1);
            end
        end
        if (req.operation != OP_UNUSED) begin
            req.operation = $urandom_range(0, 1) ? OP_SHIFT_LOW : OP_SHIFT_HIGH;
        end
        req.first_index = lo[IDX_W-1:0];
        req.last_index  = hi[IDX_W-1:0];
        return req;
    endfunction

    task automatic send_request(input t_in_req r);
        int gap;
        @(negedge clk);
        req_valid = 1'b1;
        req_data  = r;
        do @(posedge clk); while (req_stall);
        sb.note_request(r);
        burst_left--;
        if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 12);
            gap        = $urandom_range(0, 15);
            if (gap > 0) begin
                @(negedge clk);
                req_valid = 1'b0;
                req_data  = IN_REQ_W'({$urandom, $urandom});
                repeat (gap - 1) @(negedge clk);
            end
        end
    endtask

    task automatic settle();
        @(negedge clk);
        req_valid = 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_keep(input logic [CFG_IDX_W-1:0] index, input logic [KEEP_W-1:0] value);
        @(negedge clk);
        cfg_wr_en = 1'b1;
        cfg_index = index;
        cfg_data  = value;
        @(negedge clk);
        cfg_wr_en = 1'b0;
        sb.set_keep(index, value);
    endtask

    task automatic run_directed();
        send_request(make_req(OP_WRITE, 0, 63, 8'd255, 8'd255, 8'd255));
        send_request(make_req(OP_WRITE, 63, 0, 8'd255, 8'd0, 8'd170));
        send_request(make_req(OP_WRITE, 31, 17, 8'd0, 8'd255, 8'd85));
        send_request(make_req(OP_WRITE, 32, 40, 8'd170, 8'd85, 8'd0));
        send_request(make_req(OP_WRITE, 1, 2, 8'd0, 8'd0, 8'd0));
        send_request(make_req(OP_SHIFT_LOW, 0, 63, 8'd0, 8'd0, 8'd0));
        send_request(make_req(OP_SHIFT_HIGH, 0, 63, 8'd255, 8'd255, 8'd255));
        send_request(make_req(OP_WRITE, 62, 63, 8'd128, 8'd64, 8'd255));
        send_request(make_req(OP_SHIFT_LOW, 62, 63, 8'd1, 8'd2, 8'd3));
        send_request(make_req(OP_SHIFT_HIGH, 0, 1, 8'd4, 8'd5, 8'd6));
        send_request(make_req(OP_SHIFT_LOW, 10, 10, 8'd0, 8'd0, 8'd0));
        send_request(make_req(OP_SHIFT_HIGH, 40, 5, 8'd0, 8'd0, 8'd0));
        send_request(make_req(OP_SHIFT_LOW, 50, 20, 8'd0, 8'd0, 8'd0));
        send_request(make_req(OP_UNUSED, 3, 60, 8'd255, 8'd0, 8'd255));
        send_request(make_req(OP_WRITE, 5, 63, 8'd1, 8'd2, 8'd3));
        send_request(make_req(OP_SHIFT_HIGH, 0, 63, 8'd0, 8'd0, 8'd0));
        send_request(make_req(OP_SHIFT_LOW, 0, 63, 8'd0, 8'd0, 8'd0));
        send_request(make_req(OP_WRITE, 63, 63, 8'd255, 8'd255, 8'd255));
        send_request(make_req(OP_SHIFT_HIGH, 62, 63, 8'd0, 8'd0, 8'd0));
    endtask

    task automatic run_random(input int count);
        t_in_req req;
        bit      counted;
        int      done;
        done = 0;
        while (done < count) begin
            req = random_request(counted);
            send_request(req);
            if (counted) done++;
        end
    endtask

    initial begin
        sb           = new();
        rst_n        = 1'b0;
        req_valid    = 1'b0;
        req_data     = '0;
        cfg_wr_en    = 1'b0;
        cfg_index    = CFG_PIXEL_KEEP;
        cfg_data     = '0;
        hold_off_due = 1'b0;
        burst_left   = 1;
        own_settings   = '{9'd256, 9'd0, 9'd511, 9'd255, 9'd256, 9'd0, 9'd200, 9'd0};
        carry_settings = '{9'd256, 9'd0, 9'd511, 9'd128, 9'd0, 9'd256, 9'd0, 9'd0};
        own_settings[PHASES - 1]   = KEEP_W'($urandom_range(0, 511));
        carry_settings[PHASES - 1] = KEEP_W'($urandom_range(0, 511));
        carry_settings[PHASES - 2] = KEEP_W'($urandom_range(0, 511));
        repeat (12) @(negedge clk);
        rst_n = 1'b1;
        for (int phase = 0; phase < PHASES; phase++) begin
            settle();
            write_keep(CFG_PIXEL_KEEP, own_settings[phase]);
            write_keep(CFG_TRAVEL_KEEP, carry_settings[phase]);
            if (phase == 0) run_directed();
            // hold the result side off while requests keep coming
            if (phase == 2) hold_off_due = 1'b1;
            run_random(ITEMS_PER_PHASE);
        end
        @(negedge clk);
        req_valid = 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.pending() != 0) begin
            $display("%0t: %0d expected pixels never arrived", $time, sb.pending());
        end
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("PASS led_strip_decay_propagate_core");
        end else begin
            $display("FAIL led_strip_decay_propagate_core");
        end
        $finish;
    end
endmodule
